// File: rtl/npke_pkg.sv
// ----------------------------------------------------------------------------
// npke_pkg
// Types, codes and constants shared by the base packing and k-mer blocks.
// ----------------------------------------------------------------------------
package npke_pkg;

	localparam int BASES_PER_WORD  = 32;
	localparam int MAX_WORDS_DEF   = 1024;
	localparam int KMER_LEN_W      = 6;
	localparam logic [KMER_LEN_W-1:0] KMER_LEN_RESET = 6'd31;
	localparam logic [KMER_LEN_W-1:0] KMER_LEN_MAX   = 6'd32;
	localparam logic [15:0] GC_MAX = 16'hFFFF;

	localparam logic [1:0] CODE_A = 2'h0;
	localparam logic [1:0] CODE_C = 2'h1;
	localparam logic [1:0] CODE_G = 2'h2;
	localparam logic [1:0] CODE_T = 2'h3;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_FLUSH  = 2'd1,
		OP_QUERY  = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_RD_LO,
		S_RD_HI,
		S_DONE
	} state_t;

	typedef struct packed {
		logic take;
		logic exec;
		logic rd_hi;
		logic finish;
		logic drain;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic query_ok;
		logic out_free;
	} sts_t;

	function automatic logic [1:0] base_code(input logic [7:0] ch);
		logic [7:0] lc;
		lc = ch | 8'h20;
		case (lc)
			8'h63:   base_code = CODE_C;
			8'h67:   base_code = CODE_G;
			8'h74:   base_code = CODE_T;
			default: base_code = CODE_A;
		endcase
	endfunction

	function automatic logic is_gc(input logic [7:0] ch);
		logic [7:0] lc;
		lc = ch | 8'h20;
		is_gc = (lc == 8'h63) || (lc == 8'h67);
	endfunction

endpackage

// File: rtl/npke_ctrl.sv
// ----------------------------------------------------------------------------
// npke_ctrl
// Sequencer: accept an item, execute it, run the one or two word reads of a
// query, and hand the result to the output register.
// ----------------------------------------------------------------------------
module npke_ctrl
	import npke_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (sts.query_ok) state_d = S_RD_LO;
				else if (sts.out_free) state_d = S_IDLE;
				else state_d = S_DONE;
			end
			S_RD_LO: state_d = S_RD_HI;
			S_RD_HI: begin
				if (sts.out_free) state_d = S_IDLE;
				else state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			S_EXEC: begin
				cmd.exec     = 1'b1;
				cmd.load_out = !sts.query_ok && sts.out_free;
			end
			S_RD_LO: cmd.rd_hi = 1'b1;
			S_RD_HI: begin
				cmd.finish   = 1'b1;
				cmd.load_out = sts.out_free;
			end
			S_DONE: begin
				cmd.drain    = 1'b1;
				cmd.load_out = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// File: rtl/npke_dp.sv
// ----------------------------------------------------------------------------
// npke_dp
// Datapath: pending word, word store, G/C tally, k-mer extraction and the
// output register.
// ----------------------------------------------------------------------------
module npke_dp
	import npke_pkg::*;
#(
	parameter int MAX_WORDS = MAX_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [1:0]  opcode,
	input  logic [7:0]  base_char,
	input  logic [14:0] position,
	input  logic        cfg_write,
	input  logic [5:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] kmer_value,
	output logic [15:0] gc_total,
	output logic [10:0] words_stored,
	output logic        fault
);

	localparam int AW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int CW   = $clog2(MAX_WORDS + 1);
	localparam int CMPW = (CW > 11) ? CW : 11;

	logic [63:0]           mem [MAX_WORDS];
	logic [63:0]           rdata_q;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;

	op_t                   op_q;
	logic [7:0]            ch_q;
	logic [14:0]           pos_q;
	logic [KMER_LEN_W-1:0] klen_q;
	logic [63:0]           pword_q;
	logic [4:0]            pbases_q;
	logic [CW-1:0]         count_q;
	logic [15:0]           gc_q;
	logic [63:0]           w0_q;
	logic [63:0]           hold_kmer_q;
	logic                  hold_fault_q;
	logic                  out_valid_q;
	logic [63:0]           out_kmer_q;
	logic [15:0]           out_gc_q;
	logic [10:0]           out_words_q;
	logic                  out_fault_q;

	logic [63:0]           word_ins;
	logic [63:0]           store_data;
	logic                  store_req;
	logic                  full;
	logic [63:0]           pword_n;
	logic [4:0]            pbases_n;
	logic [CW-1:0]         count_n;
	logic [15:0]           gc_n;
	logic [KMER_LEN_W-1:0] k;
	logic [9:0]            div;
	logic [4:0]            md;
	logic                  two;
	logic [CMPW-1:0]       div_w;
	logic [CMPW-1:0]       div1_w;
	logic [CMPW-1:0]       count_w;
	logic                  qfault;
	logic                  exec_fault;
	logic [63:0]           w1;
	logic [127:0]          pair_sh;
	logic [63:0]           mask;
	logic [63:0]           kmer_calc;
	logic [63:0]           res_kmer;
	logic                  res_fault;
	logic                  out_free;

	always_comb begin
		full      = count_q >= CW'(MAX_WORDS);
		store_req = ((op_q == OP_APPEND) && (pbases_q == 5'd31)) ||
		            ((op_q == OP_FLUSH) && (pbases_q != 5'd0));
		word_ins  = pword_q;
		word_ins[{pbases_q, 1'b0} +: 2] = base_code(ch_q);
		store_data = (op_q == OP_APPEND) ? word_ins : pword_q;

		pword_n  = pword_q;
		pbases_n = pbases_q;
		count_n  = count_q;
		gc_n     = gc_q;
		case (op_q)
			OP_APPEND: begin
				pword_n  = store_req ? 64'd0 : word_ins;
				pbases_n = pbases_q + 5'd1;
				if (is_gc(ch_q) && (gc_q != GC_MAX)) gc_n = gc_q + 16'd1;
			end
			OP_FLUSH: begin
				if (store_req) begin
					pword_n  = 64'd0;
					pbases_n = 5'd0;
				end
			end
			OP_CLEAR: begin
				pword_n  = 64'd0;
				pbases_n = 5'd0;
				count_n  = '0;
				gc_n     = 16'd0;
			end
			default: ;
		endcase
		if (store_req && !full) count_n = count_q + CW'(1);
	end

	always_comb begin
		k       = (klen_q == 6'd0) ? 6'd1 :
		          ((klen_q > KMER_LEN_MAX) ? KMER_LEN_MAX : klen_q);
		div     = pos_q[14:5];
		md      = pos_q[4:0];
		two     = (7'(md) + 7'(k)) > 7'd32;
		div_w   = CMPW'(div);
		div1_w  = div_w + CMPW'(1);
		count_w = CMPW'(count_q);
		qfault  = (div_w >= count_w) || (two && (div1_w >= count_w));
		exec_fault = (store_req && full) || ((op_q == OP_QUERY) && qfault);

		w1        = two ? rdata_q : 64'd0;
		pair_sh   = {w1, w0_q} >> {md, 1'b0};
		mask      = (k == KMER_LEN_MAX) ? {64{1'b1}} : ((64'd1 << {k, 1'b0}) - 64'd1);
		kmer_calc = pair_sh[63:0] & mask;

		res_kmer  = cmd.exec ? 64'd0 : kmer_calc;
		res_fault = cmd.exec ? exec_fault : 1'b0;
	end

	assign out_free     = !out_valid_q || out_ready;
	assign sts.query_ok = (op_q == OP_QUERY) && !qfault;
	assign sts.out_free = out_free;

	assign wr_en   = cmd.exec && store_req && !full;
	assign rd_en   = (cmd.exec && sts.query_ok) || (cmd.rd_hi && two);
	assign rd_addr = cmd.rd_hi ? div1_w[AW-1:0] : div_w[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) mem[count_q[AW-1:0]] <= store_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q  <= op_t'(opcode);
			ch_q  <= base_char;
			pos_q <= position;
		end
		if (cmd.rd_hi) w0_q <= rdata_q;
		if (cmd.exec || cmd.finish) begin
			hold_kmer_q  <= res_kmer;
			hold_fault_q <= res_fault;
		end
		if (cmd.load_out) begin
			out_kmer_q  <= cmd.drain ? hold_kmer_q : res_kmer;
			out_fault_q <= cmd.drain ? hold_fault_q : res_fault;
			out_gc_q    <= cmd.exec ? gc_n : gc_q;
			out_words_q <= 11'(cmd.exec ? count_n : count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q      <= KMER_LEN_RESET;
			pword_q     <= 64'd0;
			pbases_q    <= 5'd0;
			count_q     <= '0;
			gc_q        <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) klen_q <= cfg_data;
			if (cmd.exec) begin
				pword_q  <= pword_n;
				pbases_q <= pbases_n;
				count_q  <= count_n;
				gc_q     <= gc_n;
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign kmer_value   = out_kmer_q;
	assign gc_total     = out_gc_q;
	assign words_stored = out_words_q;
	assign fault        = out_fault_q;

endmodule

// File: rtl/nucleotide_pack_kmer_extract_top.sv
// ----------------------------------------------------------------------------
// nucleotide_pack_kmer_extract_top
// Two-bit base packer with a word store and k-mer query.
//
// The input channel (in_valid/in_ready) carries opcode, base_char and
// position; each transfer yields exactly one result on the output channel
// (out_valid/out_ready): kmer_value, gc_total, words_stored and fault.
// The config channel (cfg_valid/cfg_ready, cfg_data) sets the k-mer length;
// cfg_ready is always high; only the user keeps writes to when the block is idle.
// One item is in work at a time; in_ready is high only while the sequencer
// is idle. out_valid rises once the item has been registered and executed.
// Append, flush, clear and a faulting query go from execution straight to
// the output register; a query that reads the store first reads the word
// holding its start, then the next if needed, via the store's one read port.
// The output register lets the next item be accepted while a result waits.
// If the receiver stalls with a result already waiting, the next result is
// held inside and further input is refused until the output frees up.
// Reset empties the store, the pending word and the tally and sets the
// k-mer length to 31; the store memory itself is not cleared.
// ----------------------------------------------------------------------------
module nucleotide_pack_kmer_extract_top
	import npke_pkg::*;
#(
	parameter int MAX_WORDS = MAX_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [7:0]  base_char,
	input  logic [14:0] position,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] kmer_value,
	output logic [15:0] gc_total,
	output logic [10:0] words_stored,
	output logic        fault,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	npke_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	npke_dp #(
		.MAX_WORDS (MAX_WORDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.opcode       (opcode),
		.base_char    (base_char),
		.position     (position),
		.cfg_write    (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kmer_value   (kmer_value),
		.gc_total     (gc_total),
		.words_stored (words_stored),
		.fault        (fault)
	);

endmodule
